// ===== rtl/fcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types and fixed-point constants for the conductor reflectance block.
// ----------------------------------------------------------------------------
package fcr_pkg;

	// fixed-point format
	localparam int FRAC_BITS = 16;
	localparam logic [16:0] ONE = 17'(1 << FRAC_BITS);

	// query transaction
	typedef struct packed {
		logic [19:0] outer_index;
		logic [16:0] cos_incidence;
		logic [19:0] ior_real_r;
		logic [19:0] ior_real_g;
		logic [19:0] ior_real_b;
		logic [19:0] ior_imag_r;
		logic [19:0] ior_imag_g;
		logic [19:0] ior_imag_b;
	} fcr_query_t;

	// result transaction
	typedef struct packed {
		logic [16:0] refl_r;
		logic [16:0] refl_g;
		logic [16:0] refl_b;
	} fcr_result_t;

endpackage

// ===== rtl/fcr_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface fcr_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fcr_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_div_pipe
// Pipelined restoring divider, one quotient bit per stage, Q stages.
// The caller supplies a partial remainder below the divisor plus the Q low
// dividend bits still to shift in.
// ----------------------------------------------------------------------------
module fcr_div_pipe #(
	parameter int D  = 20,
	parameter int Q  = 36,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [D-1:0]  rem_init,
	input  logic [Q-1:0]  dividend_lo,
	input  logic [D-1:0]  divisor,
	input  logic [TW-1:0] tag_in,
	output logic          out_valid,
	output logic [Q-1:0]  quotient,
	output logic [TW-1:0] tag_out
);

	logic          v_s   [Q];
	logic [D-1:0]  rem_s [Q];
	logic [Q-1:0]  lo_s  [Q];
	logic [Q-1:0]  quo_s [Q];
	logic [D-1:0]  den_s [Q];
	logic [TW-1:0] tag_s [Q];

	for (genvar i = 0; i < Q; i++) begin : g_st
		logic          v_p;
		logic [D-1:0]  rem_p;
		logic [Q-1:0]  lo_p;
		logic [Q-1:0]  quo_p;
		logic [D-1:0]  den_p;
		logic [TW-1:0] tag_p;
		logic [D:0]    trial;
		logic          take;

		if (i == 0) begin : g_first
			assign v_p   = in_valid;
			assign rem_p = rem_init;
			assign lo_p  = dividend_lo;
			assign quo_p = '0;
			assign den_p = divisor;
			assign tag_p = tag_in;
		end else begin : g_next
			assign v_p   = v_s[i-1];
			assign rem_p = rem_s[i-1];
			assign lo_p  = lo_s[i-1];
			assign quo_p = quo_s[i-1];
			assign den_p = den_s[i-1];
			assign tag_p = tag_s[i-1];
		end

		// shift in next dividend bit, subtract when it fits
		assign trial = {rem_p, lo_p[Q-1]};
		assign take  = (trial >= {1'b0, den_p});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? D'(trial - {1'b0, den_p}) : trial[D-1:0];
				lo_s[i]  <= lo_p << 1;
				quo_s[i] <= {quo_p[Q-2:0], take};
				den_s[i] <= den_p;
				tag_s[i] <= tag_p;
			end
		end
	end

	assign out_valid = v_s[Q-1];
	assign quotient  = quo_s[Q-1];
	assign tag_out   = tag_s[Q-1];

endmodule

// ===== rtl/fcr_isqrt_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_isqrt_pipe
// Pipelined floor integer square root, one root bit per stage, W/2 stages.
// ----------------------------------------------------------------------------
module fcr_isqrt_pipe #(
	parameter int W  = 64,
	parameter int TW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [W-1:0]   radicand,
	input  logic [TW-1:0]  tag_in,
	output logic           out_valid,
	output logic [W/2-1:0] root,
	output logic [TW-1:0]  tag_out
);

	localparam int R = W / 2;

	logic          v_s    [R];
	logic [R:0]    rem_s  [R];
	logic [R-1:0]  root_s [R];
	logic [W-1:0]  x_s    [R];
	logic [TW-1:0] tag_s  [R];

	for (genvar i = 0; i < R; i++) begin : g_st
		logic          v_p;
		logic [R:0]    rem_p;
		logic [R-1:0]  root_p;
		logic [W-1:0]  x_p;
		logic [TW-1:0] tag_p;
		logic [R+2:0]  cur;
		logic [R+2:0]  trial;
		logic          take;

		if (i == 0) begin : g_first
			assign v_p    = in_valid;
			assign rem_p  = '0;
			assign root_p = '0;
			assign x_p    = radicand;
			assign tag_p  = tag_in;
		end else begin : g_next
			assign v_p    = v_s[i-1];
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
			assign x_p    = x_s[i-1];
			assign tag_p  = tag_s[i-1];
		end

		// bring down two bits, try root*4+1
		assign cur   = {rem_p, x_p[W-1:W-2]};
		assign trial = {1'b0, root_p, 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= take ? (R+1)'(cur - trial) : cur[R:0];
				root_s[i] <= {root_p[R-2:0], take};
				x_s[i]    <= x_p << 2;
				tag_s[i]  <= tag_p;
			end
		end
	end

	assign out_valid = v_s[R-1];
	assign root      = root_s[R-1];
	assign tag_out   = tag_s[R-1];

endmodule

// ===== rtl/fcr_channel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_channel
// Reflectance datapath for one color channel: relative index division,
// two square roots, two normalizing divisions and the final average.
// ----------------------------------------------------------------------------
module fcr_channel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [19:0] n1,
	input  logic [16:0] cos_in,
	input  logic [19:0] re,
	input  logic [19:0] im,
	output logic        out_valid,
	output logic [16:0] refl
);
	import fcr_pkg::*;

	typedef struct packed {
		logic signed [32:0] t0;
		logic [16:0]        c2;
		logic [16:0]        s2;
		logic [16:0]        c;
		logic               sat;
	} a_tag_t;

	typedef struct packed {
		logic [32:0] t1;
		logic [31:0] a;
		logic [16:0] c2;
		logic [16:0] s2;
		logic [16:0] c;
		logic        sat;
	} g_tag_t;

	// stage 1: capture, clamp cosine
	logic        v_s1, nz_s1;
	logic [19:0] n1_s1, re_s1, im_s1;
	logic [16:0] c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s1 <= n1;
			nz_s1 <= (n1 == '0);
			c_s1  <= (cos_in > ONE) ? ONE : cos_in;
			re_s1 <= re;
			im_s1 <= im;
		end
	end

	// relative indices e = re/n1, k = im/n1
	logic        ve, vk, zf_d;
	logic [35:0] e_d, k_d;
	logic [16:0] c_d;

	fcr_div_pipe #(.D(20), .Q(36), .TW(1)) u_div_e (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.rem_init('0), .dividend_lo({re_s1, 16'b0}), .divisor(n1_s1),
		.tag_in(nz_s1), .out_valid(ve), .quotient(e_d), .tag_out(zf_d)
	);

	fcr_div_pipe #(.D(20), .Q(36), .TW(17)) u_div_k (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.rem_init('0), .dividend_lo({im_s1, 16'b0}), .divisor(n1_s1),
		.tag_in(c_s1), .out_valid(vk), .quotient(k_d), .tag_out(c_d)
	);

	// stage 2: squares
	logic        v_s2, sat_s2;
	logic [63:0] ee_s2, kk_s2;
	logic [33:0] cc_s2;
	logic [16:0] c_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= ve & vk;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ee_s2  <= e_d[31:0] * e_d[31:0];
			kk_s2  <= k_d[31:0] * k_d[31:0];
			cc_s2  <= {17'b0, c_d} * {17'b0, c_d};
			c_s2   <= c_d;
			sat_s2 <= zf_d | (e_d[35:32] != '0) | (k_d[35:32] != '0);
		end
	end

	// stage 3: scale, sine squared, range check
	logic [47:0] e2_w, k2_w;
	logic [48:0] ek_sum;
	logic [16:0] c2_w;
	logic        v_s3, sat_s3;
	logic [30:0] e2_s3, k2_s3;
	logic [16:0] c2_s3, s2_s3, c_s3;

	assign e2_w   = 48'(ee_s2 >> FRAC_BITS);
	assign k2_w   = 48'(kk_s2 >> FRAC_BITS);
	assign ek_sum = {1'b0, e2_w} + {1'b0, k2_w};
	assign c2_w   = 17'(cc_s2 >> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e2_s3  <= e2_w[30:0];
			k2_s3  <= k2_w[30:0];
			c2_s3  <= c2_w;
			s2_s3  <= ONE - c2_w;
			c_s3   <= c_s2;
			sat_s3 <= sat_s2 | (ek_sum >= 49'(64'd1 << 31));
		end
	end

	// stage 4: t0 and its magnitude
	logic signed [32:0] t0_w;
	logic               v_s4, sat_s4;
	logic signed [32:0] t0_s4;
	logic [31:0]        t0m_s4;
	logic [30:0]        e2_s4, k2_s4;
	logic [16:0]        c2_s4, s2_s4, c_s4;

	assign t0_w = signed'({2'b0, e2_s3}) - signed'({2'b0, k2_s3})
		- signed'({16'b0, s2_s3});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s4  <= t0_w;
			t0m_s4 <= t0_w[32] ? 32'(-t0_w) : t0_w[31:0];
			e2_s4  <= e2_s3;
			k2_s4  <= k2_s3;
			c2_s4  <= c2_s3;
			s2_s4  <= s2_s3;
			c_s4   <= c_s3;
			sat_s4 <= sat_s3;
		end
	end

	// stage 5: radicand products
	logic               v_s5, sat_s5;
	logic [63:0]        sq_s5;
	logic [61:0]        pk_s5;
	logic signed [32:0] t0_s5;
	logic [16:0]        c2_s5, s2_s5, c_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s5  <= t0m_s4 * t0m_s4;
			pk_s5  <= {31'b0, e2_s4} * {31'b0, k2_s4};
			t0_s5  <= t0_s4;
			c2_s5  <= c2_s4;
			s2_s5  <= s2_s4;
			c_s5   <= c_s4;
			sat_s5 <= sat_s4;
		end
	end

	// stage 6: radicand sum
	logic        v_s6;
	logic [63:0] rad_s6;
	a_tag_t      atag_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s6  <= sq_s5 + {pk_s5, 2'b00};
			atag_s6 <= '{t0: t0_s5, c2: c2_s5, s2: s2_s5, c: c_s5, sat: sat_s5};
		end
	end

	// a = isqrt(t0^2 + 4 e2 k2)
	logic        va;
	logic [31:0] a_d;
	a_tag_t      atag_d;

	fcr_isqrt_pipe #(.W(64), .TW($bits(a_tag_t))) u_sqrt_a (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s6),
		.radicand(rad_s6), .tag_in(atag_s6),
		.out_valid(va), .root(a_d), .tag_out(atag_d)
	);

	// stage 7: t1 and half of a + t0
	logic signed [33:0] hs_w;
	logic               v_s7;
	logic [31:0]        h_s7;
	g_tag_t             gtag_s7;

	assign hs_w = signed'({2'b0, a_d}) + 34'(atag_d.t0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= va;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s7    <= (hs_w > 0) ? hs_w[32:1] : '0;
			gtag_s7 <= '{t1: {1'b0, a_d} + {16'b0, atag_d.c2}, a: a_d,
				c2: atag_d.c2, s2: atag_d.s2, c: atag_d.c, sat: atag_d.sat};
		end
	end

	// g = isqrt(h << F)
	logic        vg;
	logic [23:0] g_d;
	g_tag_t      gtag_d;

	fcr_isqrt_pipe #(.W(48), .TW($bits(g_tag_t))) u_sqrt_g (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s7),
		.radicand({h_s7, 16'b0}), .tag_in(gtag_s7),
		.out_valid(vg), .root(g_d), .tag_out(gtag_d)
	);

	// stage 8: products c*g, c2*a, s2*s2
	logic        v_s8, sat_s8;
	logic [40:0] cg_s8;
	logic [48:0] ca_s8;
	logic [33:0] ss_s8;
	logic [32:0] t1_s8;
	logic [16:0] s2_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= vg;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cg_s8  <= {24'b0, gtag_d.c} * {17'b0, g_d};
			ca_s8  <= {32'b0, gtag_d.c2} * {17'b0, gtag_d.a};
			ss_s8  <= {17'b0, gtag_d.s2} * {17'b0, gtag_d.s2};
			t1_s8  <= gtag_d.t1;
			s2_s8  <= gtag_d.s2;
			sat_s8 <= gtag_d.sat;
		end
	end

	// stage 9: t2 and t3
	logic        v_s9, sat_s9;
	logic [25:0] t2_s9;
	logic [33:0] t3_s9;
	logic [32:0] t1_s9;
	logic [16:0] s2_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t2_s9  <= 26'(cg_s8 >> (FRAC_BITS - 1));
			t3_s9  <= {1'b0, 33'(ca_s8 >> FRAC_BITS)} + {16'b0, 18'(ss_s8 >> FRAC_BITS)};
			t1_s9  <= t1_s8;
			s2_s9  <= s2_s8;
			sat_s9 <= sat_s8;
		end
	end

	// stage 10: perpendicular numerator/denominator, t4 product
	logic        v_s10, sat_s10;
	logic [42:0] t4p_s10;
	logic [33:0] den_s10;
	logic [32:0] num_s10;
	logic [33:0] t3_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (en) v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t4p_s10 <= {17'b0, t2_s9} * {26'b0, s2_s9};
			den_s10 <= {1'b0, t1_s9} + {8'b0, t2_s9};
			num_s10 <= (t1_s9 > {7'b0, t2_s9}) ? t1_s9 - {7'b0, t2_s9} : '0;
			t3_s10  <= t3_s9;
			sat_s10 <= sat_s9;
		end
	end

	// stage 11: parallel numerator/denominator, zero divisor checks
	logic [26:0] t4_w;
	logic [34:0] den2_w;
	logic        v_s11, sat_s11;
	logic [34:0] den_s11, den2_s11;
	logic [32:0] num_s11;
	logic [33:0] num2_s11;

	assign t4_w   = 27'(t4p_s10 >> FRAC_BITS);
	assign den2_w = {1'b0, t3_s10} + {8'b0, t4_w};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s11 <= 1'b0;
		else if (en) v_s11 <= v_s10;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s11  <= {1'b0, den_s10};
			num_s11  <= num_s10;
			den2_s11 <= den2_w;
			num2_s11 <= (t3_s10 > {7'b0, t4_w}) ? t3_s10 - {7'b0, t4_w} : '0;
			sat_s11  <= sat_s10 | (den_s10 == '0) | (den2_w == '0);
		end
	end

	// rs = num/den and q = num2/den2, both at most ONE
	logic        vrs, vq, sat_rs, sat_q;
	logic [16:0] rs_d, q_d;

	fcr_div_pipe #(.D(35), .Q(17), .TW(1)) u_div_rs (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s11),
		.rem_init(35'(num_s11 >> 1)), .dividend_lo({num_s11[0], 16'b0}),
		.divisor(den_s11), .tag_in(sat_s11),
		.out_valid(vrs), .quotient(rs_d), .tag_out(sat_rs)
	);

	fcr_div_pipe #(.D(35), .Q(17), .TW(1)) u_div_q (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s11),
		.rem_init(35'(num2_s11 >> 1)), .dividend_lo({num2_s11[0], 16'b0}),
		.divisor(den2_s11), .tag_in(sat_s11),
		.out_valid(vq), .quotient(q_d), .tag_out(sat_q)
	);

	// stage 12: rp product
	logic        v_s12, sat_s12;
	logic [33:0] prod_s12;
	logic [16:0] rs_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s12 <= 1'b0;
		else if (en) v_s12 <= vrs & vq;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s12 <= {17'b0, rs_d} * {17'b0, q_d};
			rs_s12   <= rs_d;
			sat_s12  <= sat_rs | sat_q;
		end
	end

	// stage 13: mean of both terms, saturate
	logic [17:0] mean_sum;
	logic [16:0] mean_w;
	logic        v_s13;
	logic [16:0] refl_s13;

	assign mean_sum = {1'b0, rs_s12} + 18'(prod_s12 >> FRAC_BITS);
	assign mean_w   = mean_sum[17:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s13 <= 1'b0;
		else if (en) v_s13 <= v_s12;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			refl_s13 <= (sat_s12 || mean_w > ONE) ? ONE : mean_w;
		end
	end

	assign out_valid = v_s13;
	assign refl      = refl_s13;

endmodule

// ===== rtl/fresnel_conductor_reflectance_top.sv =====
`timescale 1ns / 1ps
// Datapath: from query transaction to result, the chain of
//   the 36-bit index divider, the 32- and 24-step square roots and the
//   17-step normalizing dividers, one bit per pipeline stage.
// Throughput: one query per cycle; the whole pipeline, bubbles included,
//   holds while a result waits at the output.
// Reset: arst_n clears every stage valid bit at once; payload is not reset.
// ----------------------------------------------------------------------------
// fresnel_conductor_reflectance_top
// Unpolarized conductor Fresnel reflectance for red, green and blue channels.
// ----------------------------------------------------------------------------
module fresnel_conductor_reflectance_top (
	input  logic         clk,
	input  logic         arst_n,
	fcr_stream_if.sink   query,
	fcr_stream_if.source result
);
	import fcr_pkg::*;

	logic        en;
	logic        ch_valid [3];
	logic [16:0] ch_refl  [3];
	logic [19:0] ch_re    [3];
	logic [19:0] ch_im    [3];

	// pipeline advance: output empty or being taken
	assign en          = !result.valid || result.ready;
	assign query.ready = en;

	assign ch_re[0] = query.data.ior_real_r;
	assign ch_re[1] = query.data.ior_real_g;
	assign ch_re[2] = query.data.ior_real_b;
	assign ch_im[0] = query.data.ior_imag_r;
	assign ch_im[1] = query.data.ior_imag_g;
	assign ch_im[2] = query.data.ior_imag_b;

	for (genvar ch = 0; ch < 3; ch++) begin : g_ch
		fcr_channel u_channel (
			.clk(clk), .arst_n(arst_n), .en(en), .in_valid(query.valid),
			.n1(query.data.outer_index), .cos_in(query.data.cos_incidence),
			.re(ch_re[ch]), .im(ch_im[ch]),
			.out_valid(ch_valid[ch]), .refl(ch_refl[ch])
		);
	end

	assign result.valid       = ch_valid[0];
	assign result.data.refl_r = ch_refl[0];
	assign result.data.refl_g = ch_refl[1];
	assign result.data.refl_b = ch_refl[2];

	// channels run in lockstep
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(ch_valid[0] == ch_valid[1]) && (ch_valid[0] == ch_valid[2]))
		else $error("channel valid bits diverged");

	// reflectance never exceeds one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (ch_refl[0] <= ONE && ch_refl[1] <= ONE && ch_refl[2] <= ONE))
		else $error("reflectance above one");

	// an empty output slot never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> query.ready)
		else $error("input blocked with empty output");

endmodule
